### rtl/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// immediate-implication and next-cycle checks, clocked on aclk, held off in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spq: implication check failed");

`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spq: next-cycle check failed");

`else

`define SPQ_ASSERT_IMP(lbl, ante, cons)

`define SPQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int COUNT_OUT_W   = 5;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_RPT  = 4'b1000
    } state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                      compare;
        logic                      insert;
        logic                      remove;
        logic signed [VALUE_W-1:0] key;
    } spq_ctrl_t;

endpackage

`default_nettype wire

### rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// sorted chain of value cells with insert, remove-one and find commands
// ----------------------------------------------------------------------------
// Each transaction runs through capture, a compare of the key in every
// cell at once, one shift of the chain, and the load of the result register.
// The next transaction is accepted as soon as the result is loaded, even while
// it still waits on m_tready; the result load itself waits for a free output
// register. The four-step sequencer around the cell chain steps through these.
// Stored values have no reset: a cell counts as holding a value only when
// its index is below the entry count.
`default_nettype none

module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] command, [33:2] value, [39:34] zero
    input  wire logic [spq_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] success, [1] queue_full, [33:2] head_value, [34] queue_empty,
    // [39:35] entry_count
    output logic [spq_pkg::OUT_DATA_W-1:0]         m_tdata
);

    `include "sorted_priority_queue_core_assert.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int VW    = spq_pkg::VALUE_W;

    spq_pkg::state_t                  state_reg, state_next;
    logic [spq_pkg::CMD_W-1:0]        cmd_reg;
    logic signed [VW-1:0]             key_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             success_reg, success_next;
    logic                             full_reg, full_next;
    logic                             m_tvalid_reg;
    logic [spq_pkg::OUT_DATA_W-1:0]   m_tdata_reg;

    spq_pkg::spq_ctrl_t               ctrl;
    logic signed [VW-1:0]             cell_value [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           cell_valid;
    logic [QUEUE_DEPTH-1:0]           cell_gt;
    logic [QUEUE_DEPTH-1:0]           cell_ge;
    logic [QUEUE_DEPTH-1:0]           cell_eq;

    logic                             s_accept;
    logic                             is_full;
    logic                             found;
    logic                             out_free;
    logic signed [VW-1:0]             head_value;
    logic [CNT_W+spq_pkg::COUNT_OUT_W-1:0] count_ext;

    assign s_tready = (state_reg == spq_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign found    = |cell_eq;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ctrl.compare = (state_reg == spq_pkg::ST_CMP);
    assign ctrl.insert  = (state_reg == spq_pkg::ST_UPD) &&
                          (cmd_reg == spq_pkg::CMD_INSERT) && !is_full;
    assign ctrl.remove  = (state_reg == spq_pkg::ST_UPD) &&
                          (cmd_reg == spq_pkg::CMD_REMOVE) && found;
    assign ctrl.key     = key_reg;

    // cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                 left_valid;
        logic                 left_gt;
        logic signed [VW-1:0] left_value;
        logic signed [VW-1:0] right_value;

        assign cell_valid[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            assign left_valid = 1'b1;
            assign left_gt    = 1'b0;
            assign left_value = key_reg;
        end else begin : g_body
            assign left_valid = cell_valid[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_value = '0;
        end else begin : g_inner
            assign right_value = cell_value[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .own_valid   (cell_valid[i]),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .ge          (cell_ge[i]),
            .eq          (cell_eq[i])
        );
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = spq_pkg::ST_CMP;
                end
            end
            spq_pkg::ST_CMP: begin
                state_next = spq_pkg::ST_UPD;
            end
            spq_pkg::ST_UPD: begin
                state_next = spq_pkg::ST_RPT;
            end
            spq_pkg::ST_RPT: begin
                if (out_free) begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        success_next = 1'b0;
        full_next    = 1'b0;
        case (cmd_reg)
            spq_pkg::CMD_INSERT: begin
                success_next = !is_full;
                full_next    = is_full;
                if (!is_full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::CMD_REMOVE: begin
                success_next = found;
                if (found) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            spq_pkg::CMD_FIND: begin
                success_next = found;
            end
            default: begin
                success_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spq_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == spq_pkg::ST_UPD) begin
                count_reg <= count_next;
            end
            if ((state_reg == spq_pkg::ST_RPT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign head_value = (count_reg != '0) ? cell_value[0] : '0;
    assign count_ext  = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
        end
        if (state_reg == spq_pkg::ST_UPD) begin
            success_reg <= success_next;
            full_reg    <= full_next;
        end
        if ((state_reg == spq_pkg::ST_RPT) && out_free) begin
            m_tdata_reg <= {count_ext[spq_pkg::COUNT_OUT_W-1:0], (count_reg == '0),
                            head_value, full_reg, success_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_NXT(a_accept_to_cmp, s_accept, state_reg == spq_pkg::ST_CMP)
    `SPQ_ASSERT_NXT(a_count_hold, state_reg != spq_pkg::ST_UPD, $stable(count_reg))
    `SPQ_ASSERT_NXT(a_insert_grows, ctrl.insert, count_reg == $past(count_reg) + CNT_W'(1))

    for (genvar k = 0; k + 1 < QUEUE_DEPTH; k++) begin : g_order_chk
        `SPQ_ASSERT_IMP(a_sorted, (state_reg == spq_pkg::ST_IDLE) && cell_valid[k+1], cell_value[k] <= cell_value[k+1])
    end

endmodule

`default_nettype wire

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds a value, compares it to the broadcast
// key and takes a neighbor's value or the key when the chain shifts
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic                               aclk,
    input  wire spq_pkg::spq_ctrl_t                 ctrl,
    input  wire logic                               own_valid,
    input  wire logic                               left_valid,
    input  wire logic                               left_gt,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
    output logic signed [spq_pkg::VALUE_W-1:0]      value,
    output logic                                    gt,
    output logic                                    ge,
    output logic                                    eq
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic                               gt_reg;
    logic                               ge_reg;
    logic                               eq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.compare) begin
            gt_reg <= own_valid && (value_reg >  ctrl.key);
            ge_reg <= own_valid && (value_reg >= ctrl.key);
            eq_reg <= own_valid && (value_reg == ctrl.key);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            // larger values move one slot toward the tail
            if (left_gt) begin
                value_reg <= left_value;
            end else if (left_valid && (!own_valid || gt_reg)) begin
                value_reg <= ctrl.key;
            end
        end else if (ctrl.remove && ge_reg) begin
            value_reg <= right_value;
        end
    end

    assign value = value_reg;
    assign gt    = gt_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire
